// ----- hdl/xdpcm_pkg.sv -----
// Shared constants and types for the Xan DPCM audio decoder.
package xdpcm_pkg;

   localparam int SECTION_SIZE = 1471;
   localparam int POS_W = 12;

   localparam logic [POS_W-1:0] SEC_LEN_MONO   = POS_W'(SECTION_SIZE);
   localparam logic [POS_W-1:0] SEC_LEN_STEREO = POS_W'(2 * SECTION_SIZE);
   localparam logic [POS_W-1:0] HDR_LEN_MONO   = POS_W'(2);
   localparam logic [POS_W-1:0] HDR_LEN_STEREO = POS_W'(4);

   localparam logic [3:0] SHIFT_RESET = 4'd4;
   localparam logic [3:0] SHIFT_MAX   = 4'd15;

   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [3:0]         shift;
   } code_result_type;

endpackage

// ----- hdl/xdpcm_code_unit.sv -----
// Per-code-byte update: shift adaptation, scaled delta and saturating predictor add.
module xdpcm_code_unit
   import xdpcm_pkg::*;
(
   input  logic [7:0]         code_byte,
   input  logic [3:0]         shift_cur,
   input  logic signed [15:0] predictor_cur,
   output code_result_type    result
);

   logic [1:0]         low_bits;
   logic signed [5:0]  shift_sum;
   logic [3:0]         shift_next;
   logic signed [15:0] delta_base;
   logic signed [15:0] delta;
   logic signed [16:0] pred_sum;

   assign low_bits = code_byte[1:0];

   always_comb begin
      if (low_bits == 2'b11) begin
         shift_sum = $signed({2'b00, shift_cur}) + 6'sd1;
      end else begin
         shift_sum = $signed({2'b00, shift_cur}) - $signed({3'b000, low_bits, 1'b0});
      end
      if (shift_sum[5]) begin
         shift_next = 4'd0;
      end else if (shift_sum[4]) begin
         shift_next = SHIFT_MAX;
      end else begin
         shift_next = shift_sum[3:0];
      end
   end

   // The signed byte with its low two bits cleared, scaled by 256.
   assign delta_base = $signed({code_byte[7:2], 10'b0});
   assign delta      = delta_base >>> shift_next;
   assign pred_sum   = {predictor_cur[15], predictor_cur} + {delta[15], delta};

   always_comb begin
      result.shift = shift_next;
      if (pred_sum[16] != pred_sum[15]) begin
         result.sample = pred_sum[16] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         result.sample = pred_sum[15:0];
      end
   end

endmodule

// ----- hdl/xan_dpcm_decoder_top.sv -----
// Top level of the Xan DPCM audio decoder: input register, section tracking and result register.
module xan_dpcm_decoder_top
   import xdpcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_stereo,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_code_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_channel,
   output logic               rsp_code_nonzero,
   output logic               rsp_last_sample
);

   // The decoder takes one chunk byte per word and sustains one word per clock
   // while the result register is not held by rsp_stall. A byte is registered
   // in the input register, where it is decoded against the predictor and shift
   // state; a code byte then goes to the result register, which drives the
   // result port.
   // Header bytes give no sample. The state updates in the same cycle the byte
   // leaves the input register, so the next byte follows without a gap. Input
   // stalls only when a decoded code byte finds the result register held by
   // rsp_stall. A word with last byte set returns the state to its reset
   // values, keeping the stereo setting.

   logic              stereo_ff;
   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic              rsp_channel_ff;
   logic              rsp_nonzero_ff;
   logic              rsp_last_ff;

   logic signed [15:0] pred_ff [2];
   logic signed [15:0] pred_in [2];
   logic [3:0]         shift_ff [2];
   logic [3:0]         shift_in [2];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               chan_ff, chan_in;
   logic [7:0]         hdr_low_ff, hdr_low_in;

   logic [POS_W-1:0] sec_len, hdr_len, pos_cur, pos_inc;
   logic             is_header;
   logic             code_ch;
   logic             out_free;
   logic             advance;
   logic             req_take;
   code_result_type  code_res;

   assign sec_len   = stereo_ff ? SEC_LEN_STEREO : SEC_LEN_MONO;
   assign hdr_len   = stereo_ff ? HDR_LEN_STEREO : HDR_LEN_MONO;
   assign pos_cur   = (pos_ff >= sec_len) ? '0 : pos_ff;
   assign pos_inc   = pos_cur + POS_W'(1);
   assign is_header = pos_cur < hdr_len;
   assign code_ch   = stereo_ff & chan_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (is_header || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   xdpcm_code_unit u_code (
      .code_byte     (in_byte_ff),
      .shift_cur     (shift_ff[code_ch]),
      .predictor_cur (pred_ff[code_ch]),
      .result        (code_res)
   );

   always_comb begin
      pred_in    = pred_ff;
      shift_in   = shift_ff;
      pos_in     = pos_ff;
      chan_in    = chan_ff;
      hdr_low_in = hdr_low_ff;
      if (advance) begin
         if (is_header) begin
            if (!pos_cur[0]) begin
               hdr_low_in = in_byte_ff;
            end else begin
               pred_in[pos_cur[1]] = $signed({in_byte_ff, hdr_low_ff});
               if (pos_cur == hdr_len - POS_W'(1)) begin
                  shift_in[0] = SHIFT_RESET;
                  shift_in[1] = SHIFT_RESET;
                  chan_in     = 1'b0;
               end
            end
            pos_in = pos_inc;
         end else begin
            pred_in[code_ch]  = code_res.sample;
            shift_in[code_ch] = code_res.shift;
            chan_in           = stereo_ff & ~code_ch;
            pos_in            = (pos_inc >= sec_len) ? '0 : pos_inc;
         end
         if (in_last_ff) begin
            pred_in[0]  = '0;
            pred_in[1]  = '0;
            shift_in[0] = SHIFT_RESET;
            shift_in[1] = SHIFT_RESET;
            pos_in      = '0;
            chan_in     = 1'b0;
            hdr_low_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pred_ff[0]   <= '0;
         pred_ff[1]   <= '0;
         shift_ff[0]  <= SHIFT_RESET;
         shift_ff[1]  <= SHIFT_RESET;
         pos_ff       <= '0;
         chan_ff      <= 1'b0;
         hdr_low_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            stereo_ff <= csr_stereo;
         end
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && !is_header) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         pred_ff    <= pred_in;
         shift_ff   <= shift_in;
         pos_ff     <= pos_in;
         chan_ff    <= chan_in;
         hdr_low_ff <= hdr_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_code_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && !is_header) begin
         rsp_sample_ff  <= code_res.sample;
         rsp_channel_ff <= code_ch;
         rsp_nonzero_ff <= in_byte_ff != 8'd0;
         rsp_last_ff    <= in_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_code_nonzero = rsp_nonzero_ff;
   assign rsp_last_sample  = rsp_last_ff;

`ifndef SYNTHESIS
   // The section position never reaches the stereo section length.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < SEC_LEN_STEREO)
      else $error("section position out of range");

   // A header byte never loads the result register.
   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && is_header && !(rsp_valid_ff && rsp_stall)) |=> !rsp_valid_ff)
      else $error("header byte produced a sample");

   // The input side stalls only behind a held code byte.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && !is_header && rsp_valid_ff && rsp_stall))
      else $error("input stalled without cause");

   // A channel 1 sample only comes out in stereo mode.
   a_stereo_channel: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_header && code_ch) |-> stereo_ff)
      else $error("right channel decoded in mono");
`endif

endmodule

// ----- tb/xan_dpcm_decoder_top_test.sv -----
// Self-checking testbench for the Xan DPCM audio decoder top level.
module xan_dpcm_decoder_top_test
   import xdpcm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES  = 800;

   typedef struct {
      logic signed [15:0] sample;
      logic               channel;
      logic               nonzero;
      logic               last;
   } decoded_sample_type;

   // Tracks the decoder state and holds the samples still owed by the block.
   class sample_board_type;
      bit                 stereo;
      logic [15:0]        chan_pred [2];
      logic [3:0]         chan_shift [2];
      int                 position;
      logic               next_chan;
      logic [7:0]         low_half;
      decoded_sample_type pending_samples [$];
      int                 failures;

      function new();
         stereo = 1'b0;
         failures = 0;
         restart();
      endfunction

      function void restart();
         chan_pred[0] = '0;
         chan_pred[1] = '0;
         chan_shift[0] = SHIFT_RESET;
         chan_shift[1] = SHIFT_RESET;
         position = 0;
         next_chan = 1'b0;
         low_half = '0;
      endfunction

      function void take_byte(logic [7:0] code, logic last);
         int hdr_len;
         int sec_len;
         int p;
         int low;
         int sh;
         int val;
         int acc;
         logic ch;
         decoded_sample_type s;
         hdr_len = stereo ? int'(HDR_LEN_STEREO) : int'(HDR_LEN_MONO);
         sec_len = stereo ? int'(SEC_LEN_STEREO) : int'(SEC_LEN_MONO);
         p = position;
         // A position left beyond the section by a mode change opens a new section.
         if (p >= sec_len) p = 0;
         if (p < hdr_len) begin
            ch = p[1];
            if (!p[0]) begin
               low_half = code;
            end else begin
               chan_pred[ch] = {code, low_half};
               if (p == hdr_len - 1) begin
                  chan_shift[0] = SHIFT_RESET;
                  chan_shift[1] = SHIFT_RESET;
                  next_chan = 1'b0;
               end
            end
            p++;
         end else begin
            ch = stereo ? next_chan : 1'b0;
            low = int'(code[1:0]);
            sh = int'(chan_shift[ch]);
            if (low == 3) sh++;
            else sh -= 2 * low;
            if (sh < 0) sh = 0;
            else if (sh > int'(SHIFT_MAX)) sh = int'(SHIFT_MAX);
            chan_shift[ch] = sh[3:0];
            val = (int'($signed(code)) - low) * 256;
            acc = int'($signed(chan_pred[ch])) + (val >>> sh);
            if (acc < int'(SAMPLE_MIN)) acc = int'(SAMPLE_MIN);
            else if (acc > int'(SAMPLE_MAX)) acc = int'(SAMPLE_MAX);
            chan_pred[ch] = acc[15:0];
            s.sample = acc[15:0];
            s.channel = ch;
            s.nonzero = (code != 8'h00);
            s.last = last;
            pending_samples.push_back(s);
            next_chan = stereo ? ~ch : 1'b0;
            p++;
            if (p >= sec_len) p = 0;
         end
         position = p & 'hFFF;
         if (last) restart();
      endfunction

      function void check_sample(logic signed [15:0] sample, logic channel,
                                 logic nonzero, logic last);
         decoded_sample_type e;
         if (pending_samples.size() == 0) begin
            $error("unexpected sample word: sample %0d channel %0b", sample, channel);
            failures++;
            return;
         end
         e = pending_samples.pop_front();
         if (sample !== e.sample) begin
            $error("sample: expected %0d, got %0d", e.sample, sample);
            failures++;
         end
         if (channel !== e.channel) begin
            $error("channel: expected %0b, got %0b", e.channel, channel);
            failures++;
         end
         if (nonzero !== e.nonzero) begin
            $error("code_nonzero: expected %0b, got %0b", e.nonzero, nonzero);
            failures++;
         end
         if (last !== e.last) begin
            $error("last_sample: expected %0b, got %0b", e.last, last);
            failures++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_stereo = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_code_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;
   logic               rsp_channel;
   logic               rsp_code_nonzero;
   logic               rsp_last_sample;

   sample_board_type board;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int stall_left = 0;

   xan_dpcm_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_stereo       (csr_stereo),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_channel      (rsp_channel),
      .rsp_code_nonzero (rsp_code_nonzero),
      .rsp_last_sample  (rsp_last_sample)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: check each accepted word, then hold stall for a random stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_sample(rsp_sample, rsp_channel, rsp_code_nonzero, rsp_last_sample);
            stall_left = rx_idle_on ? $urandom_range(0, 10) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   task automatic send_byte(input logic [7:0] code, input logic last);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= code;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      board.take_byte(code, last);
   endtask

   // Stops sending and waits until every owed sample has come back.
   task automatic drain_decoder();
      req_valid <= 1'b0;
      while (board.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stereo(input logic mode);
      csr_valid <= 1'b1;
      csr_stereo <= mode;
      do @(posedge clock); while (!csr_ready);
      board.stereo = mode;
      csr_valid <= 1'b0;
   endtask

   // Random code byte; in climb mode most bytes push the shift upward.
   function automatic logic [7:0] pick_code(input bit climb);
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: c = 8'h00;
            1: c = 8'h7F;
            2: c = 8'h80;
            default: c = 8'hFF;
         endcase
      end
      if (climb && $urandom_range(0, 4) != 0) c[1:0] = 2'b11;
      return c;
   endfunction

   task automatic send_run(input int count, input bit climb, input bit allow_last);
      for (int i = 0; i < count; i++)
         send_byte(pick_code(climb), allow_last && ($urandom_range(0, 39) == 0));
   endtask

   initial begin
      int sent;
      int n;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Mono: header to full scale, then positive and negative saturation,
      // shift clamped at zero, a zero code, last on a code and on a header byte.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h7C, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h7C, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h55, 1'b1);
      drain_decoder();

      // Stereo: both headers at opposite extremes, alternating channels.
      write_stereo(1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7C, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hC3, 1'b1);
      drain_decoder();

      // A short mono run after the stereo chunk.
      write_stereo(1'b0);
      send_run(40, 1'b0, 1'b0);
      drain_decoder();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 1) == 1) write_stereo(1'($urandom_range(0, 1)));
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(5, 80);
         send_run(n, $urandom_range(0, 3) == 0, 1'b1);
         sent += n;
         drain_decoder();
      end

      if (board.failures == 0) begin
         $display("xan_dpcm_decoder_top verification clean");
      end else begin
         $display("xan_dpcm_decoder_top verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("xan_dpcm_decoder_top verification failed");
      $finish;
   end

endmodule
